// File: rtl/core/tgl_pkg.sv
// shared types, codes and saturation helpers for the text glyph layout block
package tgl_pkg;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_CHAR  = 2'd2;
  localparam logic [1:0] REQ_END   = 2'd3;

  localparam logic RK_QUAD   = 1'b0;
  localparam logic RK_EXTENT = 1'b1;

  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] CFG_BASELINE = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_LINE_ADV = 1'b1;
  localparam logic [15:0] BASELINE_RST = 16'd384;
  localparam logic [15:0] LINE_ADV_RST = 16'd448;

  localparam logic [7:0] FIRST_CODE   = 8'd32;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam int GLYPH_COUNT_DEF = 95;
  localparam int QDEPTH = 2;

  localparam logic [19:0] S20_MAX = 20'h7FFFF;
  localparam logic [19:0] S20_MIN = 20'h80000;
  localparam logic [19:0] U20_MAX = 20'hFFFFF;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_NEWLINE = 2'd1,
    OP_GLYPH   = 2'd2,
    OP_END     = 2'd3
  } op_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] u0;
    logic [15:0] v0;
    logic [15:0] u1;
    logic [15:0] v1;
    logic [15:0] adv;
  } glyph_t;

  typedef struct packed {
    op_t         op;
    logic [19:0] x;
    logic [19:0] y;
    logic [31:0] color;
    glyph_t      glyph;
  } qent_t;

  typedef struct packed {
    logic [15:0] baseline_offset;
    logic [15:0] line_advance;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [19:0] quad_x;
    logic [19:0] quad_y;
    logic [15:0] quad_w;
    logic [15:0] quad_h;
    logic [15:0] uv_left;
    logic [15:0] uv_top;
    logic [15:0] uv_right;
    logic [15:0] uv_bottom;
    logic [31:0] color;
    logic [19:0] extent_w;
    logic [19:0] extent_h;
  } res_t;

  // signed 22-bit sum down to signed 20 bits
  function automatic logic [19:0] sat_s20(input logic [21:0] v);
    logic [19:0] r;
    if ((v[21:19] == 3'b000) || (v[21:19] == 3'b111)) r = v[19:0];
    else if (v[21]) r = S20_MIN;
    else r = S20_MAX;
    return r;
  endfunction

  // signed 20 bits down to signed 16 bits
  function automatic logic [15:0] sat_s16(input logic [19:0] v);
    logic [15:0] r;
    if ((v[19:15] == 5'b00000) || (v[19:15] == 5'b11111)) r = v[15:0];
    else if (v[19]) r = 16'h8000;
    else r = 16'h7FFF;
    return r;
  endfunction

endpackage

// File: rtl/core/text_glyph_layout.sv
// top level of the text glyph layout block
//
// requests arrive on in_valid/in_ready with req_type selecting glyph load,
// string start, character or string end. results leave on out_valid/out_ready:
// one glyph quad per drawable character and one extent result per string end.
// baseline_offset and line_advance are written through cfg_we/cfg_index/cfg_data
// only while no request is in flight; the user must keep to this, the block does
// not enforce it. a request is taken every cycle unless the front stage waits on
// a full queue. the glyph table read and the front stage load on the accepting
// edge; the request passes through the queue into the output register. the glyph
// table has one write and one registered read port, read once per in-range
// character; the back end retires one request per cycle unless a result stalls.
// when the receiver stalls, the output register holds its result, the back
// end keeps popping requests that give no result, and the two entry queue
// plus the front stage fill before in_ready drops.
// reset clears pen and measurement state, the queue and the output valid,
// and restores the register defaults; the glyph table keeps its contents
// and must be loaded before use.
module text_glyph_layout #(
  parameter int GLYPH_COUNT = tgl_pkg::GLYPH_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [tgl_pkg::CFG_AW-1:0] cfg_index,
  input  logic [15:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                req_type,
  input  logic [7:0]                char_code,
  input  logic signed [19:0]        coord_x,
  input  logic signed [19:0]        coord_y,
  input  logic signed [15:0]        box_right,
  input  logic signed [15:0]        box_bottom,
  input  logic [15:0]               tex_left,
  input  logic [15:0]               tex_top,
  input  logic [15:0]               tex_right,
  input  logic [15:0]               tex_bottom,
  input  logic [15:0]               pen_advance,
  input  logic [31:0]               color_rgba,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      result_kind,
  output logic signed [19:0]        quad_x,
  output logic signed [19:0]        quad_y,
  output logic [15:0]               quad_w,
  output logic [15:0]               quad_h,
  output logic [15:0]               uv_left,
  output logic [15:0]               uv_top,
  output logic [15:0]               uv_right,
  output logic [15:0]               uv_bottom,
  output logic [31:0]               quad_color,
  output logic [19:0]               extent_w,
  output logic [19:0]               extent_h
);

  import tgl_pkg::*;

  cfg_t  cfg;
  logic  q_push;
  logic  q_ready;
  qent_t q_data;
  logic  q_pop;
  logic  q_valid;
  qent_t q_head;
  res_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.baseline_offset <= BASELINE_RST;
      cfg.line_advance    <= LINE_ADV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASELINE: cfg.baseline_offset <= cfg_data;
        CFG_LINE_ADV: cfg.line_advance    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tgl_front #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .char_code   (char_code),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .box_right   (box_right),
    .box_bottom  (box_bottom),
    .tex_left    (tex_left),
    .tex_top     (tex_top),
    .tex_right   (tex_right),
    .tex_bottom  (tex_bottom),
    .pen_advance (pen_advance),
    .color_rgba  (color_rgba),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  tgl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  tgl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign result_kind = res.kind;
  assign quad_x      = res.quad_x;
  assign quad_y      = res.quad_y;
  assign quad_w      = res.quad_w;
  assign quad_h      = res.quad_h;
  assign uv_left     = res.uv_left;
  assign uv_top      = res.uv_top;
  assign uv_right    = res.uv_right;
  assign uv_bottom   = res.uv_bottom;
  assign quad_color  = res.color;
  assign extent_w    = res.extent_w;
  assign extent_h    = res.extent_h;

endmodule

// File: rtl/core/tgl_ram.sv
// generic single write port ram with registered read
module tgl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/tgl_front.sv
// front end: accepts requests, loads the glyph table, classifies and looks up glyphs
module tgl_front #(
  parameter int GLYPH_COUNT = tgl_pkg::GLYPH_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    req_type,
  input  logic [7:0]    char_code,
  input  logic [19:0]   coord_x,
  input  logic [19:0]   coord_y,
  input  logic [15:0]   box_right,
  input  logic [15:0]   box_bottom,
  input  logic [15:0]   tex_left,
  input  logic [15:0]   tex_top,
  input  logic [15:0]   tex_right,
  input  logic [15:0]   tex_bottom,
  input  logic [15:0]   pen_advance,
  input  logic [31:0]   color_rgba,
  input  logic          q_ready,
  output logic          q_push,
  output tgl_pkg::qent_t q_data
);

  import tgl_pkg::*;

  localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  logic [8:0]    code_off;
  logic          in_range;
  logic          is_nl;
  logic          accept;
  logic          enq;
  op_t           op_next;
  logic          wr_en;
  logic          rd_en;
  glyph_t        wdata;
  glyph_t        rdata;
  logic          s1_valid;
  op_t           s1_op;
  logic [19:0]   s1_x;
  logic [19:0]   s1_y;
  logic [31:0]   s1_color;

  assign code_off = {1'b0, char_code} - {1'b0, FIRST_CODE};
  assign in_range = (char_code >= FIRST_CODE) && (code_off < 9'(GLYPH_COUNT));
  assign is_nl    = (char_code == NEWLINE_CODE);
  assign in_ready = !s1_valid || q_ready;
  assign accept   = in_valid && in_ready;
  assign q_push   = s1_valid && q_ready;

  always_comb begin
    enq = 1'b0;
    op_next = OP_GLYPH;
    case (req_type)
      REQ_START: begin
        enq = 1'b1;
        op_next = OP_START;
      end
      REQ_END: begin
        enq = 1'b1;
        op_next = OP_END;
      end
      REQ_CHAR: begin
        enq = is_nl || in_range;
        op_next = is_nl ? OP_NEWLINE : OP_GLYPH;
      end
      default: begin
        enq = 1'b0;
        op_next = OP_GLYPH;
      end
    endcase
  end

  assign wr_en = accept && (req_type == REQ_LOAD) && in_range;
  assign rd_en = accept && (req_type == REQ_CHAR) && !is_nl && in_range;

  always_comb begin
    wdata.left   = sat_s16(coord_x);
    wdata.top    = sat_s16(coord_y);
    wdata.right  = box_right;
    wdata.bottom = box_bottom;
    wdata.u0     = tex_left;
    wdata.v0     = tex_top;
    wdata.u1     = tex_right;
    wdata.v1     = tex_bottom;
    wdata.adv    = pen_advance;
  end

  tgl_ram #(
    .WIDTH($bits(glyph_t)),
    .DEPTH(GLYPH_COUNT)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (code_off[AW-1:0]),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (code_off[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept && enq;
    end
    if (accept) begin
      s1_op    <= op_next;
      s1_x     <= coord_x;
      s1_y     <= coord_y;
      s1_color <= color_rgba;
    end
  end

  always_comb begin
    q_data.op    = s1_op;
    q_data.x     = s1_x;
    q_data.y     = s1_y;
    q_data.color = s1_color;
    q_data.glyph = rdata;
  end

endmodule

// File: rtl/core/tgl_queue.sv
// short queue of classified requests between front and back
module tgl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tgl_pkg::qent_t push_data,
  output logic           push_ready,
  input  logic           pop,
  output logic           head_valid,
  output tgl_pkg::qent_t head
);

  import tgl_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  qent_t            entries [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign push_ready = (count != (QAW + 1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/core/tgl_back.sv
// back end: pen and measurement state, quad and extent results, output register
module tgl_back (
  input  logic           clk,
  input  logic           rst,
  input  tgl_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  tgl_pkg::qent_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output tgl_pkg::res_t  res
);

  import tgl_pkg::*;

  logic [19:0] line_origin_x;
  logic [19:0] pen_x;
  logic [19:0] pen_y;
  logic [19:0] cur_line_width;
  logic [19:0] widest_line;
  logic [19:0] text_height;
  logic [31:0] draw_color;

  logic [19:0] line_origin_x_next;
  logic [19:0] pen_x_next;
  logic [19:0] pen_y_next;
  logic [19:0] cur_line_width_next;
  logic [19:0] widest_line_next;
  logic [19:0] text_height_next;
  logic [31:0] draw_color_next;

  res_t        res_next;
  logic        produce;
  glyph_t      g;
  logic [16:0] gw;
  logic [16:0] gh;
  logic        nonempty;
  logic [20:0] cur_sum;
  logic [20:0] height_sum;
  logic [19:0] widest_max;

  assign g        = q_head.glyph;
  assign gw       = {g.right[15], g.right} - {g.left[15], g.left};
  assign gh       = {g.bottom[15], g.bottom} - {g.top[15], g.top};
  assign nonempty = !gw[16] && (gw != '0) && !gh[16] && (gh != '0);
  assign cur_sum    = {1'b0, cur_line_width} + {5'b0, g.adv};
  assign height_sum = {1'b0, text_height} + {5'b0, cfg.line_advance};
  assign widest_max = (cur_line_width > widest_line) ? cur_line_width : widest_line;

  always_comb begin
    line_origin_x_next  = line_origin_x;
    pen_x_next          = pen_x;
    pen_y_next          = pen_y;
    cur_line_width_next = cur_line_width;
    widest_line_next    = widest_line;
    text_height_next    = text_height;
    draw_color_next     = draw_color;
    res_next            = '0;
    produce             = 1'b0;
    case (q_head.op)
      OP_START: begin
        line_origin_x_next  = q_head.x;
        pen_x_next          = q_head.x;
        pen_y_next          = sat_s20({{2{q_head.y[19]}}, q_head.y}
                                      + {6'b0, cfg.baseline_offset});
        draw_color_next     = q_head.color;
        cur_line_width_next = '0;
        widest_line_next    = '0;
        text_height_next    = {4'b0, cfg.line_advance};
      end
      OP_NEWLINE: begin
        widest_line_next    = widest_max;
        cur_line_width_next = '0;
        pen_x_next          = line_origin_x;
        pen_y_next          = sat_s20({{2{pen_y[19]}}, pen_y} + {6'b0, cfg.line_advance});
        text_height_next    = height_sum[20] ? U20_MAX : height_sum[19:0];
      end
      OP_GLYPH: begin
        produce             = nonempty;
        res_next.kind       = RK_QUAD;
        res_next.quad_x     = sat_s20({{2{pen_x[19]}}, pen_x} + {{6{g.left[15]}}, g.left});
        res_next.quad_y     = sat_s20({{2{pen_y[19]}}, pen_y} + {{6{g.top[15]}}, g.top});
        res_next.quad_w     = gw[15:0];
        res_next.quad_h     = gh[15:0];
        res_next.uv_left    = g.u0;
        res_next.uv_top     = g.v0;
        res_next.uv_right   = g.u1;
        res_next.uv_bottom  = g.v1;
        res_next.color      = draw_color;
        pen_x_next          = sat_s20({{2{pen_x[19]}}, pen_x} + {6'b0, g.adv});
        cur_line_width_next = cur_sum[20] ? U20_MAX : cur_sum[19:0];
      end
      OP_END: begin
        produce           = 1'b1;
        res_next.kind     = RK_EXTENT;
        res_next.extent_w = widest_max;
        res_next.extent_h = text_height;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  assign q_pop = q_valid && (!produce || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_origin_x  <= '0;
      pen_x          <= '0;
      pen_y          <= '0;
      cur_line_width <= '0;
      widest_line    <= '0;
      text_height    <= '0;
      draw_color     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        line_origin_x  <= line_origin_x_next;
        pen_x          <= pen_x_next;
        pen_y          <= pen_y_next;
        cur_line_width <= cur_line_width_next;
        widest_line    <= widest_line_next;
        text_height    <= text_height_next;
        draw_color     <= draw_color_next;
      end
      if (q_pop && produce) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (q_pop && produce) begin
      res <= res_next;
    end
  end

endmodule

// File: tb/text_glyph_layout_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for text_glyph_layout: glyph loads, strings and extents
module text_glyph_layout_tb;
  import tgl_pkg::*;

  localparam int PEN_MAX  = 524287;
  localparam int PEN_MIN  = -524288;
  localparam int SPAN_MAX = 1048575;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  code;
    logic [19:0] x;
    logic [19:0] y;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] u0;
    logic [15:0] v0;
    logic [15:0] u1;
    logic [15:0] v1;
    logic [15:0] adv;
    logic [31:0] color;
  } layout_req_t;

  class layout_board;
    glyph_t      glyphs[GLYPH_COUNT_DEF];
    int          origin_x;
    int          pen_x;
    int          pen_y;
    int          line_w;
    int          widest;
    int          height;
    logic [31:0] color;
    int          baseline;
    int          line_adv;
    res_t        pending_output[$];
    int          failures;
    int          shown;

    function new();
      origin_x = 0;
      pen_x    = 0;
      pen_y    = 0;
      line_w   = 0;
      widest   = 0;
      height   = 0;
      color    = '0;
      baseline = BASELINE_RST;
      line_adv = LINE_ADV_RST;
      failures = 0;
      shown    = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function void set_register(logic [CFG_AW-1:0] idx, logic [15:0] value);
      if (idx == CFG_BASELINE) baseline = value;
      else line_adv = value;
    endfunction

    function int outstanding();
      return pending_output.size();
    endfunction

    function void note_request(layout_req_t r);
      int     slot;
      glyph_t g;
      res_t   q;
      longint x0;
      longint y0;
      longint gw;
      longint gh;
      slot = int'(r.code) - int'(FIRST_CODE);
      q = '0;
      case (r.kind)
        REQ_LOAD: begin
          if (slot >= 0 && slot < GLYPH_COUNT_DEF) begin
            g.left   = 16'(clamp($signed(r.x), -32768, 32767));
            g.top    = 16'(clamp($signed(r.y), -32768, 32767));
            g.right  = r.right;
            g.bottom = r.bottom;
            g.u0     = r.u0;
            g.v0     = r.v0;
            g.u1     = r.u1;
            g.v1     = r.v1;
            g.adv    = r.adv;
            glyphs[slot] = g;
          end
        end
        REQ_START: begin
          origin_x = $signed(r.x);
          pen_x    = origin_x;
          pen_y    = int'(clamp(longint'($signed(r.y)) + baseline, PEN_MIN, PEN_MAX));
          color    = r.color;
          line_w   = 0;
          widest   = 0;
          height   = line_adv;
        end
        REQ_END: begin
          q.kind     = RK_EXTENT;
          q.extent_w = 20'((widest > line_w) ? widest : line_w);
          q.extent_h = 20'(height);
          pending_output.push_back(q);
        end
        default: begin
          if (r.code == NEWLINE_CODE) begin
            if (line_w > widest) widest = line_w;
            line_w = 0;
            pen_x  = origin_x;
            pen_y  = int'(clamp(longint'(pen_y) + line_adv, PEN_MIN, PEN_MAX));
            height = int'(clamp(longint'(height) + line_adv, 0, SPAN_MAX));
          end else if (slot >= 0 && slot < GLYPH_COUNT_DEF) begin
            g  = glyphs[slot];
            x0 = $signed(g.left);
            y0 = $signed(g.top);
            gw = longint'($signed(g.right)) - x0;
            gh = longint'($signed(g.bottom)) - y0;
            if (gw > 0 && gh > 0) begin
              q.kind      = RK_QUAD;
              q.quad_x    = 20'(clamp(longint'(pen_x) + x0, PEN_MIN, PEN_MAX));
              q.quad_y    = 20'(clamp(longint'(pen_y) + y0, PEN_MIN, PEN_MAX));
              q.quad_w    = 16'(gw);
              q.quad_h    = 16'(gh);
              q.uv_left   = g.u0;
              q.uv_top    = g.v0;
              q.uv_right  = g.u1;
              q.uv_bottom = g.v1;
              q.color     = color;
              pending_output.push_back(q);
            end
            pen_x  = int'(clamp(longint'(pen_x) + longint'(g.adv), PEN_MIN, PEN_MAX));
            line_w = int'(clamp(longint'(line_w) + longint'(g.adv), 0, SPAN_MAX));
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        failures++;
        if (shown < 10) begin
          shown++;
          $display("mismatch %s: expected %h, actual %h", name, want, got);
        end
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_output.size() == 0) begin
        failures++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: kind %0d x %h y %h w %h h %h",
                   got.kind, got.quad_x, got.quad_y, got.extent_w, got.extent_h);
        end
        return;
      end
      want = pending_output.pop_front();
      compare_field("result_kind", want.kind, got.kind);
      compare_field("quad_x", want.quad_x, got.quad_x);
      compare_field("quad_y", want.quad_y, got.quad_y);
      compare_field("quad_w", want.quad_w, got.quad_w);
      compare_field("quad_h", want.quad_h, got.quad_h);
      compare_field("uv_left", want.uv_left, got.uv_left);
      compare_field("uv_top", want.uv_top, got.uv_top);
      compare_field("uv_right", want.uv_right, got.uv_right);
      compare_field("uv_bottom", want.uv_bottom, got.uv_bottom);
      compare_field("quad_color", want.color, got.color);
      compare_field("extent_w", want.extent_w, got.extent_w);
      compare_field("extent_h", want.extent_h, got.extent_h);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_index = '0;
  logic [15:0]         cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          req_type = REQ_LOAD;
  logic [7:0]          char_code = '0;
  logic signed [19:0]  coord_x = '0;
  logic signed [19:0]  coord_y = '0;
  logic signed [15:0]  box_right = '0;
  logic signed [15:0]  box_bottom = '0;
  logic [15:0]         tex_left = '0;
  logic [15:0]         tex_top = '0;
  logic [15:0]         tex_right = '0;
  logic [15:0]         tex_bottom = '0;
  logic [15:0]         pen_advance = '0;
  logic [31:0]         color_rgba = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                result_kind;
  logic signed [19:0]  quad_x;
  logic signed [19:0]  quad_y;
  logic [15:0]         quad_w;
  logic [15:0]         quad_h;
  logic [15:0]         uv_left;
  logic [15:0]         uv_top;
  logic [15:0]         uv_right;
  logic [15:0]         uv_bottom;
  logic [31:0]         quad_color;
  logic [19:0]         extent_w;
  logic [19:0]         extent_h;

  layout_board board;
  res_t        seen;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_len = 0;
  int          hold_left = 0;
  int          useful_sent = 0;
  bit          known[GLYPH_COUNT_DEF];
  logic [7:0]  loaded_codes[$];

  text_glyph_layout dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .char_code  (char_code),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .box_right  (box_right),
    .box_bottom (box_bottom),
    .tex_left   (tex_left),
    .tex_top    (tex_top),
    .tex_right  (tex_right),
    .tex_bottom (tex_bottom),
    .pen_advance(pen_advance),
    .color_rgba (color_rgba),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_kind(result_kind),
    .quad_x     (quad_x),
    .quad_y     (quad_y),
    .quad_w     (quad_w),
    .quad_h     (quad_h),
    .uv_left    (uv_left),
    .uv_top     (uv_top),
    .uv_right   (uv_right),
    .uv_bottom  (uv_bottom),
    .quad_color (quad_color),
    .extent_w   (extent_w),
    .extent_h   (extent_h)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen = '{result_kind, quad_x, quad_y, quad_w, quad_h, uv_left, uv_top,
               uv_right, uv_bottom, quad_color, extent_w, extent_h};
      board.check_result(seen);
    end
  end

  function automatic layout_req_t noisy_req(logic [1:0] kind, logic [7:0] code);
    logic [223:0] bits;
    layout_req_t  r;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = layout_req_t'(bits[$bits(layout_req_t)-1:0]);
    r.kind = kind;
    r.code = code;
    return r;
  endfunction

  function automatic layout_req_t glyph_load_req();
    layout_req_t r;
    int          lft;
    int          top;
    if ($urandom_range(99) < 85) r = noisy_req(REQ_LOAD, 8'($urandom_range(32, 126)));
    else r = noisy_req(REQ_LOAD, 8'($urandom_range(255)));
    if ($urandom_range(99) < 70) begin
      lft = int'($urandom_range(0, 48)) - 16;
      top = -int'($urandom_range(0, 400));
      r.x      = 20'(lft);
      r.y      = 20'(top);
      r.right  = 16'(lft + int'($urandom_range(0, 320)));
      r.bottom = 16'(top + int'($urandom_range(0, 480)));
      if ($urandom_range(99) < 90) r.adv = 16'($urandom_range(0, 400));
    end
    return r;
  endfunction

  function automatic layout_req_t string_start_req();
    layout_req_t r;
    r = noisy_req(REQ_START, 8'($urandom_range(255)));
    if ($urandom_range(99) < 60) begin
      r.x = 20'(int'($urandom_range(0, 8000)) - 4000);
      r.y = 20'(int'($urandom_range(0, 8000)) - 4000);
    end
    return r;
  endfunction

  // only loaded glyphs, newline or codes outside the glyph range
  function automatic layout_req_t char_req();
    int         p;
    logic [7:0] code;
    p = $urandom_range(99);
    if (p < 78 && loaded_codes.size() > 0)
      code = loaded_codes[$urandom_range(loaded_codes.size() - 1)];
    else if (p < 90) code = NEWLINE_CODE;
    else if ($urandom_range(1)) code = 8'($urandom_range(0, 31));
    else code = 8'($urandom_range(127, 255));
    return noisy_req(REQ_CHAR, code);
  endfunction

  task automatic send_request(input layout_req_t r);
    int slot;
    bit hit;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= r.kind;
    char_code   <= r.code;
    coord_x     <= r.x;
    coord_y     <= r.y;
    box_right   <= r.right;
    box_bottom  <= r.bottom;
    tex_left    <= r.u0;
    tex_top     <= r.v0;
    tex_right   <= r.u1;
    tex_bottom  <= r.v1;
    pen_advance <= r.adv;
    color_rgba  <= r.color;
    do @(posedge clk); while (!in_ready);
    board.note_request(r);
    slot = int'(r.code) - int'(FIRST_CODE);
    hit  = (slot >= 0 && slot < GLYPH_COUNT_DEF);
    if (r.kind == REQ_LOAD && hit && !known[slot]) begin
      known[slot] = 1'b1;
      loaded_codes.push_back(r.code);
    end
    if (!(!hit && (r.kind == REQ_LOAD || (r.kind == REQ_CHAR && r.code != NEWLINE_CODE))))
      useful_sent++;
  endtask

  task automatic write_register(input logic [CFG_AW-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_register(idx, value);
  endtask

  // drop valid, drain all results, then let requests with no result retire
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_directed();
    layout_req_t r;
    send_request(noisy_req(REQ_END, 8'd0));
    r = noisy_req(REQ_LOAD, 8'd65);
    r.x = 20'd16;
    r.y = 20'(-160);
    r.right = 16'd136;
    r.bottom = 16'd0;
    r.adv = 16'd144;
    send_request(r);
    // empty box, still advances
    r = noisy_req(REQ_LOAD, FIRST_CODE);
    r.x = 20'd8;
    r.y = 20'd0;
    r.right = 16'd8;
    r.adv = 16'd64;
    send_request(r);
    // widest box, edges saturate low
    r = noisy_req(REQ_LOAD, 8'd126);
    r.x = 20'h80000;
    r.y = 20'h80000;
    r.right = 16'h7FFF;
    r.bottom = 16'h7FFF;
    r.adv = 16'hFFFF;
    send_request(r);
    // edges saturate high, box empty
    r = noisy_req(REQ_LOAD, 8'd33);
    r.x = 20'h7FFFF;
    r.y = 20'h7FFFF;
    r.right = 16'h8000;
    r.bottom = 16'h8000;
    r.adv = 16'd0;
    send_request(r);
    send_request(noisy_req(REQ_LOAD, 8'd127));
    send_request(noisy_req(REQ_LOAD, 8'd31));
    r = noisy_req(REQ_START, 8'd0);
    r.x = 20'd100;
    r.y = 20'd200;
    r.color = 32'h11223344;
    send_request(r);
    send_request(noisy_req(REQ_CHAR, 8'd65));
    send_request(noisy_req(REQ_CHAR, FIRST_CODE));
    send_request(noisy_req(REQ_CHAR, 8'd126));
    send_request(noisy_req(REQ_CHAR, NEWLINE_CODE));
    send_request(noisy_req(REQ_CHAR, 8'd0));
    send_request(noisy_req(REQ_CHAR, 8'd255));
    send_request(noisy_req(REQ_CHAR, 8'd65));
    send_request(noisy_req(REQ_END, 8'd0));
    r = noisy_req(REQ_START, 8'd255);
    r.x = 20'h7FFFF;
    r.y = 20'h7FFFF;
    r.color = 32'hFFFFFFFF;
    send_request(r);
    send_request(noisy_req(REQ_CHAR, 8'd126));
    send_request(noisy_req(REQ_CHAR, 8'd33));
    send_request(noisy_req(REQ_END, 8'd0));
    r = noisy_req(REQ_START, 8'd0);
    r.x = 20'h80000;
    r.y = 20'h80000;
    r.color = 32'h0;
    send_request(r);
    send_request(noisy_req(REQ_CHAR, 8'd126));
    send_request(noisy_req(REQ_CHAR, NEWLINE_CODE));
    send_request(noisy_req(REQ_END, 8'd0));
    send_request(noisy_req(REQ_END, 8'd0));
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input logic [15:0] base,
                           input logic [15:0] adv, input int hold, input int budget);
    int target;
    int n;
    int pick;
    logic [1:0] kind;
    wait_idle();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    hold_len       = hold;
    write_register(CFG_BASELINE, base);
    write_register(CFG_LINE_ADV, adv);
    target = useful_sent + budget;
    while (useful_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_request(string_start_req());
        n = $urandom_range(1, 20);
        repeat (n) begin
          if ($urandom_range(99) < 5) send_request(glyph_load_req());
          else send_request(char_req());
        end
        send_request(noisy_req(REQ_END, 8'($urandom_range(255))));
      end else if (pick < 85) begin
        send_request(glyph_load_req());
      end else begin
        kind = 2'($urandom_range(3));
        if (kind == REQ_CHAR) send_request(char_req());
        else send_request(noisy_req(kind, 8'($urandom_range(255))));
      end
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_phase(0, 0, 16'd0, 16'd0, 0, 370);
    run_phase(54, 0, 16'hFFFF, 16'hFFFF, 0, 370);
    run_phase(0, 54, 16'($urandom_range(65535)), 16'($urandom_range(65535)), 0, 370);
    run_phase(29, 29, BASELINE_RST, LINE_ADV_RST, 0, 370);
    run_phase(0, 0, 16'($urandom_range(1000)), 16'($urandom_range(1000)), 400, 370);
    wait_idle();
    if (board.failures == 0) begin
      $display("[text_glyph_layout] OK");
    end else begin
      $display("[text_glyph_layout] ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[text_glyph_layout] ERROR");
    $finish;
  end

endmodule
